// ----- rtl/led_blink_pattern_classifier_top_defines.svh -----
// Assertion macros for the LED blink pattern classifier.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef LED_BLINK_PATTERN_CLASSIFIER_TOP_DEFINES_SVH
`define LED_BLINK_PATTERN_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LBPC_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LBPC_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lbpc_pkg.sv -----
// Shared types and constants for the LED blink pattern classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package lbpc_pkg;

  // Result pattern codes.
  typedef enum logic [2:0] {
    PAT_UNKNOWN = 3'd0,
    PAT_FAST    = 3'd1,
    PAT_SLOW    = 3'd2,
    PAT_SOLID   = 3'd3,
    PAT_OFF     = 3'd4
  } pattern_t;

  // Register indexes (byte address = 4 * index).
  typedef enum logic [2:0] {
    REG_FAST_PERIOD_MIN = 3'd0,
    REG_FAST_PERIOD_MAX = 3'd1,
    REG_FAST_PHASE_MIN  = 3'd2,
    REG_FAST_PHASE_MAX  = 3'd3,
    REG_SLOW_PERIOD_MIN = 3'd4,
    REG_SLOW_PERIOD_MAX = 3'd5,
    REG_SLOW_PHASE_MIN  = 3'd6,
    REG_SLOW_PHASE_MAX  = 3'd7
  } reg_idx_t;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned DUR_W  = 16;

  // floor(x / 1000) for any 32-bit x: (x * ceil(2^41 / 1000)) >> 41.
  localparam int unsigned    DIV_SHIFT = 41;
  localparam logic [31:0]    DIV_MUL   = 32'd2199023256;
  // Quotient width: 2^32 / 1000 < 2^23.
  localparam int unsigned    MS_W      = 23;
  localparam logic [DUR_W-1:0] SAT16   = 16'hFFFF;

  typedef struct packed {
    logic        cmd;
    logic [31:0] edge_time_us;
    logic        pin_level;
    logic [31:0] poll_time_ms;
  } lbpc_in_t;

  typedef struct packed {
    pattern_t           pattern;
    logic [DUR_W-1:0]   on_duration_ms;
    logic [DUR_W-1:0]   off_duration_ms;
    logic [DUR_W-1:0]   period_length_ms;
  } lbpc_out_t;

  typedef struct packed {
    logic [DUR_W-1:0] period_min;
    logic [DUR_W-1:0] period_max;
    logic [DUR_W-1:0] phase_min;
    logic [DUR_W-1:0] phase_max;
  } window_t;

  typedef struct packed {
    window_t fast;
    window_t slow;
  } lbpc_cfg_t;

  localparam lbpc_cfg_t CFG_RESET = '{
    fast: '{period_min: 16'd100, period_max: 16'd400,
            phase_min:  16'd50,  phase_max:  16'd200},
    slow: '{period_min: 16'd800, period_max: 16'd1600,
            phase_min:  16'd400, phase_max:  16'd800}
  };

  // Item after level tracking and the ms divides.
  typedef struct packed {
    logic              is_poll;
    logic              level_change;
    logic              prev_level;
    logic [MS_W-1:0]   dur_ms;
    logic [MS_W-1:0]   edge_ms;
    logic              pin_level;
    logic [31:0]       poll_time_ms;
  } lbpc_mid_t;

endpackage

`default_nettype wire

// ----- rtl/lbpc_stream_if.sv -----
// Valid/ready stream channel carrying one payload struct per transfer.
// Payload type is set by the instantiating module.
`default_nettype none

interface lbpc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/lbpc_cfg.sv -----
// APB-style register file holding the fast and slow blink windows.
// Depends on lbpc_pkg.
`default_nettype none

module lbpc_cfg
  import lbpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output lbpc_cfg_t              cfg
);

  lbpc_cfg_t        cfg_r;
  lbpc_cfg_t        cfg_nxt;
  reg_idx_t         idx;
  logic [DUR_W-1:0] wval;
  logic [DUR_W-1:0] rval;

  assign idx  = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wval = pwdata[DUR_W-1:0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_FAST_PERIOD_MIN: cfg_nxt.fast.period_min = wval;
        REG_FAST_PERIOD_MAX: cfg_nxt.fast.period_max = wval;
        REG_FAST_PHASE_MIN:  cfg_nxt.fast.phase_min  = wval;
        REG_FAST_PHASE_MAX:  cfg_nxt.fast.phase_max  = wval;
        REG_SLOW_PERIOD_MIN: cfg_nxt.slow.period_min = wval;
        REG_SLOW_PERIOD_MAX: cfg_nxt.slow.period_max = wval;
        REG_SLOW_PHASE_MIN:  cfg_nxt.slow.phase_min  = wval;
        REG_SLOW_PHASE_MAX:  cfg_nxt.slow.phase_max  = wval;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FAST_PERIOD_MIN: rval = cfg_r.fast.period_min;
      REG_FAST_PERIOD_MAX: rval = cfg_r.fast.period_max;
      REG_FAST_PHASE_MIN:  rval = cfg_r.fast.phase_min;
      REG_FAST_PHASE_MAX:  rval = cfg_r.fast.phase_max;
      REG_SLOW_PERIOD_MIN: rval = cfg_r.slow.period_min;
      REG_SLOW_PERIOD_MAX: rval = cfg_r.slow.period_max;
      REG_SLOW_PHASE_MIN:  rval = cfg_r.slow.phase_min;
      REG_SLOW_PHASE_MAX:  rval = cfg_r.slow.phase_max;
      default:             rval = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign prdata = DATA_W'(rval);
  assign cfg    = cfg_r;

endmodule

`default_nettype wire

// ----- rtl/lbpc_front.sv -----
// Level tracker and microsecond-to-millisecond divide stage.
// Depends on lbpc_pkg; feeds lbpc_classify through a registered lbpc_mid_t.
`default_nettype none

module lbpc_front
  import lbpc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  lbpc_in_t       item,
  output lbpc_mid_t      mid
);

  logic        level_r;
  logic        level_nxt;
  logic [31:0] start_r;
  logic [31:0] start_nxt;
  logic        change;
  logic [31:0] diff_us;
  lbpc_mid_t   mid_r;
  lbpc_mid_t   mid_nxt;

  // Reciprocal multiply; exact for the whole 32-bit range.
  function automatic logic [MS_W-1:0] div_ms(input logic [31:0] x);
    logic [63:0] prod;
    prod   = 64'(x) * 64'(DIV_MUL);
    div_ms = prod[DIV_SHIFT +: MS_W];
  endfunction

  assign change  = !item.cmd && (item.pin_level != level_r);
  assign diff_us = item.edge_time_us - start_r;

  // Glitch or not, a level change always moves the level start.
  always_comb begin
    level_nxt = level_r;
    start_nxt = start_r;
    if (en && change) begin
      level_nxt = item.pin_level;
      start_nxt = item.edge_time_us;
    end
  end

  always_comb begin
    mid_nxt.is_poll      = item.cmd;
    mid_nxt.level_change = change;
    mid_nxt.prev_level   = level_r;
    mid_nxt.dur_ms       = div_ms(diff_us);
    mid_nxt.edge_ms      = div_ms(item.edge_time_us);
    mid_nxt.pin_level    = item.pin_level;
    mid_nxt.poll_time_ms = item.poll_time_ms;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b1;
      start_r <= '0;
    end else begin
      level_r <= level_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid = mid_r;

endmodule

`default_nettype wire

// ----- rtl/lbpc_classify.sv -----
// Duration bookkeeping, window matching, quiet detection and result register.
// Depends on lbpc_pkg; takes lbpc_mid_t from lbpc_front.
`default_nettype none

module lbpc_classify
  import lbpc_pkg::*;
#(
  parameter int unsigned GLITCH_LIMIT_MS = 5,
  parameter int unsigned QUIET_LIMIT_MS  = 3000
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  lbpc_mid_t mid,
  input  lbpc_cfg_t cfg,
  output lbpc_out_t res
);

  logic [DUR_W-1:0] on_r, on_nxt;
  logic [DUR_W-1:0] off_r, off_nxt;
  logic [DUR_W-1:0] period_r, period_nxt;
  pattern_t         pattern_r, pattern_nxt;
  logic [MS_W-1:0]  last_edge_r, last_edge_nxt;
  logic [DUR_W-1:0] dur_sat;
  logic             glitch;
  logic [DUR_W:0]   sum;
  logic [31:0]      idle_ms;
  lbpc_out_t        res_r;

  function automatic logic win_hit(input window_t w, input logic [DUR_W-1:0] per,
                                   input logic [DUR_W-1:0] on_v,
                                   input logic [DUR_W-1:0] off_v);
    win_hit = (per  >= w.period_min) && (per  <= w.period_max) &&
              (on_v >= w.phase_min)  && (on_v <= w.phase_max) &&
              (off_v >= w.phase_min) && (off_v <= w.phase_max);
  endfunction

  assign glitch  = mid.dur_ms < MS_W'(GLITCH_LIMIT_MS);
  assign dur_sat = (|mid.dur_ms[MS_W-1:DUR_W]) ? SAT16 : mid.dur_ms[DUR_W-1:0];
  assign idle_ms = mid.poll_time_ms - 32'(last_edge_r);

  always_comb begin
    on_nxt        = on_r;
    off_nxt       = off_r;
    period_nxt    = period_r;
    pattern_nxt   = pattern_r;
    last_edge_nxt = last_edge_r;
    sum           = '0;
    if (mid.is_poll) begin
      if (idle_ms >= 32'(QUIET_LIMIT_MS)) begin
        pattern_nxt = mid.pin_level ? PAT_OFF : PAT_SOLID;
      end
    end else if (mid.level_change && !glitch) begin
      // low level = LED on
      if (!mid.prev_level) begin
        on_nxt = dur_sat;
      end else begin
        off_nxt = dur_sat;
      end
      if ((on_nxt != '0) && (off_nxt != '0)) begin
        sum        = {1'b0, on_nxt} + {1'b0, off_nxt};
        period_nxt = sum[DUR_W] ? SAT16 : sum[DUR_W-1:0];
        if (win_hit(cfg.fast, period_nxt, on_nxt, off_nxt)) begin
          pattern_nxt = PAT_FAST;
        end else if (win_hit(cfg.slow, period_nxt, on_nxt, off_nxt)) begin
          pattern_nxt = PAT_SLOW;
        end
      end
      last_edge_nxt = mid.edge_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r        <= '0;
      off_r       <= '0;
      period_r    <= '0;
      pattern_r   <= PAT_UNKNOWN;
      last_edge_r <= '0;
    end else if (en) begin
      on_r        <= on_nxt;
      off_r       <= off_nxt;
      period_r    <= period_nxt;
      pattern_r   <= pattern_nxt;
      last_edge_r <= last_edge_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= '{pattern: pattern_nxt, on_duration_ms: on_nxt,
                 off_duration_ms: off_nxt, period_length_ms: period_nxt};
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ----- rtl/led_blink_pattern_classifier_top.sv -----
// Top level of the LED blink pattern classifier: channel handshakes and stages.
// Depends on lbpc_pkg, lbpc_stream_if, lbpc_cfg, lbpc_front, lbpc_classify.
//
// Classifies an active-low status LED from edge and poll items. One item is
// accepted per clock unless back-pressure has filled the stages, and every item
// yields exactly one result via the input register, the level tracker with the
// 32x32 reciprocal multiply that turns microseconds into milliseconds, then the
// duration / window / quiet stage that writes the result register. Each stage
// advances when the one behind it is empty or moving, so input transfers
// continue while a result waits at the output until the input and middle stages
// are both full. No clearing pass after reset. Window registers sit at byte
// addresses 0x00..0x1C. Write them only while idle; the block does not check.
`default_nettype none
`include "led_blink_pattern_classifier_top_defines.svh"

module led_blink_pattern_classifier_top
  import lbpc_pkg::*;
#(
  parameter int unsigned GLITCH_LIMIT_MS = 5,
  parameter int unsigned QUIET_LIMIT_MS  = 3000
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  lbpc_stream_if.sink            in_ch,
  lbpc_stream_if.source          out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  logic      in_v_r, in_v_nxt;
  logic      mid_v_r, mid_v_nxt;
  logic      out_v_r, out_v_nxt;
  logic      out_adv;
  logic      mid_adv;
  logic      in_rdy;
  logic      in_xfer;
  lbpc_in_t  item_r;
  lbpc_mid_t mid;
  lbpc_cfg_t cfg;
  lbpc_out_t res;

  assign out_adv = !out_v_r || out_ch.ready;
  assign mid_adv = !mid_v_r || out_adv;
  assign in_rdy  = !in_v_r || mid_adv;
  assign in_xfer = in_ch.valid && in_rdy;

  always_comb begin
    in_v_nxt  = in_rdy  ? in_ch.valid : in_v_r;
    mid_v_nxt = mid_adv ? in_v_r      : mid_v_r;
    out_v_nxt = out_adv ? mid_v_r     : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      mid_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      mid_v_r <= mid_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_ch.payload;
    end
  end

  lbpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  lbpc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (mid_adv && in_v_r),
    .item  (item_r),
    .mid   (mid)
  );

  lbpc_classify #(
    .GLITCH_LIMIT_MS (GLITCH_LIMIT_MS),
    .QUIET_LIMIT_MS  (QUIET_LIMIT_MS)
  ) u_classify (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (out_adv && mid_v_r),
    .mid   (mid),
    .cfg   (cfg),
    .res   (res)
  );

  assign in_ch.ready    = in_rdy;
  assign out_ch.valid   = out_v_r;
  assign out_ch.payload = res;
  assign pready         = 1'b1;

  // An empty input stage never back-pressures.
  `LBPC_CHK_NOW(a_in_free_ready, !in_v_r, in_rdy, "input stage empty but not ready")
  // A transfer always lands in the input stage.
  `LBPC_CHK_NEXT(a_in_capture, in_xfer, in_v_r, "accepted item lost at input stage")
  // A stalled middle item is kept.
  `LBPC_CHK_NEXT(a_mid_hold, mid_v_r && !out_adv, mid_v_r, "middle item dropped on stall")
  // A moving middle item shows up as a result.
  `LBPC_CHK_NEXT(a_mid_to_out, mid_v_r && out_adv, out_v_r, "middle item did not reach output")

endmodule

`default_nettype wire

// ----- dv/lbpc_tb_pkg.sv -----
`timescale 1ns / 100ps
// Command codes shared by the classifier testbench and its checker.
// No dependencies.
package lbpc_tb_pkg;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_POLL = 1'b1;

endpackage

// ----- dv/lbpc_pattern_checker.sv -----
`timescale 1ns / 100ps
// Checker for the LED blink pattern classifier: follows window register writes,
// predicts the status record for every accepted item and compares the outputs.
// Depends on lbpc_pkg and lbpc_tb_pkg.
module lbpc_pattern_checker
  import lbpc_pkg::*;
  import lbpc_tb_pkg::*;
#(
  parameter int unsigned GLITCH_LIMIT_MS = 5,
  parameter int unsigned QUIET_LIMIT_MS  = 3000
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  lbpc_in_t          in_item,
  input  logic              out_valid,
  input  logic              out_ready,
  input  lbpc_out_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int unsigned       pending,
  output int unsigned       error_count
);

  lbpc_cfg_t   windows;
  logic        led_level;
  logic [31:0] level_start_us;
  logic [31:0] last_edge_ms;
  logic [15:0] on_ms;
  logic [15:0] off_ms;
  logic [15:0] per_ms;
  pattern_t    pattern;

  lbpc_out_t   expected_status_q[$];

  function automatic logic fits(input logic [15:0] v, input logic [15:0] lo,
                                input logic [15:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic logic blink_match(input window_t w);
    return fits(per_ms, w.period_min, w.period_max) &&
           fits(on_ms, w.phase_min, w.phase_max) &&
           fits(off_ms, w.phase_min, w.phase_max);
  endfunction

  task automatic classify_item(input lbpc_in_t it, output lbpc_out_t status);
    logic [31:0] span_ms;
    logic [31:0] idle_ms;
    logic [15:0] sat_ms;
    logic [16:0] sum_ms;
    if (it.cmd == CMD_EDGE) begin
      if (it.pin_level != led_level) begin
        span_ms = (it.edge_time_us - level_start_us) / 32'd1000;
        // short pulses only move the level and its start
        if (span_ms >= GLITCH_LIMIT_MS) begin
          sat_ms = (span_ms > 32'h0000_FFFF) ? SAT16 : span_ms[15:0];
          if (led_level == 1'b0) begin
            on_ms = sat_ms;
          end else begin
            off_ms = sat_ms;
          end
          if (on_ms != 16'd0 && off_ms != 16'd0) begin
            sum_ms = {1'b0, on_ms} + {1'b0, off_ms};
            per_ms = sum_ms[16] ? SAT16 : sum_ms[15:0];
            if (blink_match(windows.fast)) begin
              pattern = PAT_FAST;
            end else if (blink_match(windows.slow)) begin
              pattern = PAT_SLOW;
            end
          end
          last_edge_ms = it.edge_time_us / 32'd1000;
        end
        led_level      = it.pin_level;
        level_start_us = it.edge_time_us;
      end
    end else begin
      idle_ms = it.poll_time_ms - last_edge_ms;
      if (idle_ms >= QUIET_LIMIT_MS) begin
        pattern = it.pin_level ? PAT_OFF : PAT_SOLID;
      end
    end
    status.pattern          = pattern;
    status.on_duration_ms   = on_ms;
    status.off_duration_ms  = off_ms;
    status.period_length_ms = per_ms;
  endtask

  always @(posedge clk) begin : track
    lbpc_out_t want;
    if (!rst_n) begin
      windows        = CFG_RESET;
      led_level      = 1'b1;
      level_start_us = '0;
      last_edge_ms   = '0;
      on_ms          = '0;
      off_ms         = '0;
      per_ms         = '0;
      pattern        = PAT_UNKNOWN;
      error_count    = 0;
      expected_status_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_FAST_PERIOD_MIN: windows.fast.period_min = pwdata[15:0];
          REG_FAST_PERIOD_MAX: windows.fast.period_max = pwdata[15:0];
          REG_FAST_PHASE_MIN:  windows.fast.phase_min  = pwdata[15:0];
          REG_FAST_PHASE_MAX:  windows.fast.phase_max  = pwdata[15:0];
          REG_SLOW_PERIOD_MIN: windows.slow.period_min = pwdata[15:0];
          REG_SLOW_PERIOD_MAX: windows.slow.period_max = pwdata[15:0];
          REG_SLOW_PHASE_MIN:  windows.slow.phase_min  = pwdata[15:0];
          REG_SLOW_PHASE_MAX:  windows.slow.phase_max  = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        classify_item(in_item, want);
        expected_status_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_status_q.size() == 0) begin
          if (error_count < 10) begin
            $display("%0t: status with no item pending: pat %0d on %0d off %0d per %0d",
                     $realtime, out_item.pattern, out_item.on_duration_ms,
                     out_item.off_duration_ms, out_item.period_length_ms);
          end
          error_count++;
        end else begin
          want = expected_status_q.pop_front();
          if (out_item.pattern != want.pattern ||
              out_item.on_duration_ms != want.on_duration_ms ||
              out_item.off_duration_ms != want.off_duration_ms ||
              out_item.period_length_ms != want.period_length_ms) begin
            if (error_count < 10) begin
              $display("%0t: mismatch exp pat/on/off/per %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       $realtime, want.pattern, want.on_duration_ms,
                       want.off_duration_ms, want.period_length_ms, out_item.pattern,
                       out_item.on_duration_ms, out_item.off_duration_ms,
                       out_item.period_length_ms);
            end
            error_count++;
          end
        end
      end
    end
    pending <= expected_status_q.size();
  end

endmodule

// ----- dv/tb_led_blink_pattern_classifier_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the LED blink pattern classifier: drives edge and poll
// items, window writes and output back-pressure; lbpc_pattern_checker judges.
// Depends on lbpc_pkg, lbpc_stream_if, lbpc_tb_pkg and the block itself.
module tb_led_blink_pattern_classifier_top;
  import lbpc_pkg::*;
  import lbpc_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SEGMENT_ITEMS = 290;
  localparam int unsigned STALL_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lbpc_stream_if #(.payload_t(lbpc_in_t))  in_ch ();
  lbpc_stream_if #(.payload_t(lbpc_out_t)) out_ch ();

  int unsigned src_idle_pct = 34;
  int unsigned snk_idle_pct = 66;
  logic        stall_req;
  logic        stall_taken = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned pending;
  int unsigned error_count;

  // blink generator position: time of the last toggle and level after it
  logic [31:0] gen_t_us;
  logic        gen_lvl;

  always #5 clk = ~clk;

  led_blink_pattern_classifier_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lbpc_pattern_checker status_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_item     (in_ch.payload),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_item    (out_ch.payload),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pending     (pending),
    .error_count (error_count)
  );

  // output side: random holds, plus one long hold once requested
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (stall_req && !stall_taken) begin
      out_ch.ready <= 1'b0;
      stall_left   <= STALL_CYCLES;
      stall_taken  <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic lbpc_in_t mk_edge(input logic [31:0] t_us, input logic lvl);
    lbpc_in_t it;
    it.cmd          = CMD_EDGE;
    it.edge_time_us = t_us;
    it.pin_level    = lvl;
    it.poll_time_ms = $urandom();
    return it;
  endfunction

  function automatic lbpc_in_t mk_poll(input logic [31:0] t_ms, input logic lvl);
    lbpc_in_t it;
    it.cmd          = CMD_POLL;
    it.edge_time_us = $urandom();
    it.pin_level    = lvl;
    it.poll_time_ms = t_ms;
    return it;
  endfunction

  function automatic lbpc_cfg_t rand_windows(input logic wild);
    lbpc_cfg_t w;
    if (wild) begin
      w = lbpc_cfg_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    end else begin
      w.fast.period_min = 16'($urandom_range(0, 300));
      w.fast.period_max = w.fast.period_min + 16'($urandom_range(0, 600));
      w.fast.phase_min  = 16'($urandom_range(0, 100));
      w.fast.phase_max  = w.fast.phase_min + 16'($urandom_range(0, 300));
      w.slow.period_min = 16'($urandom_range(300, 1200));
      w.slow.period_max = w.slow.period_min + 16'($urandom_range(0, 1500));
      w.slow.phase_min  = 16'($urandom_range(150, 600));
      w.slow.phase_max  = w.slow.phase_min + 16'($urandom_range(0, 700));
    end
    return w;
  endfunction

  task automatic send_item(input lbpc_in_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // pending is registered, so always look past the current edge
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  // leaves psel/penable high; load_windows drops them after the last write
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic load_windows(input lbpc_cfg_t w);
    write_reg(REG_FAST_PERIOD_MIN, w.fast.period_min);
    write_reg(REG_FAST_PERIOD_MAX, w.fast.period_max);
    write_reg(REG_FAST_PHASE_MIN,  w.fast.phase_min);
    write_reg(REG_FAST_PHASE_MAX,  w.fast.phase_max);
    write_reg(REG_SLOW_PERIOD_MIN, w.slow.period_min);
    write_reg(REG_SLOW_PERIOD_MAX, w.slow.period_max);
    write_reg(REG_SLOW_PHASE_MIN,  w.slow.phase_min);
    write_reg(REG_SLOW_PHASE_MAX,  w.slow.phase_max);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly blink trains in bursts of one rhythm, with polls, same-level
  // edges and fully random items mixed in.
  task automatic run_random(input int unsigned n);
    int unsigned done_cnt;
    int unsigned burst;
    int unsigned roll;
    int unsigned lo_ms;
    int unsigned hi_ms;
    logic [31:0] dt_us;
    logic [31:0] poll_ms;
    lbpc_in_t    it;
    done_cnt = 0;
    burst    = 0;
    lo_ms    = 40;
    hi_ms    = 220;
    while (done_cnt < n) begin
      if (burst == 0) begin
        roll  = $urandom_range(99);
        burst = $urandom_range(8, 24);
        if (roll < 35) begin
          lo_ms = 40;
          hi_ms = 220;
        end else if (roll < 70) begin
          lo_ms = 350;
          hi_ms = 850;
        end else if (roll < 80) begin
          lo_ms = 0;
          hi_ms = 8;
        end else begin
          lo_ms = 1;
          hi_ms = 70000;
        end
      end
      roll = $urandom_range(99);
      if (roll < 70) begin
        burst--;
        if ($urandom_range(99) < 3) begin
          dt_us = $urandom();
        end else begin
          dt_us = $urandom_range(hi_ms * 1000, lo_ms * 1000);
        end
        gen_t_us = gen_t_us + dt_us;
        gen_lvl  = ~gen_lvl;
        it       = mk_edge(gen_t_us, gen_lvl);
        done_cnt++;
      end else if (roll < 78) begin
        // level unchanged: the block leaves its state alone
        it = mk_edge(gen_t_us + $urandom_range(0, 5000000), gen_lvl);
        done_cnt++;
      end else if (roll < 93) begin
        if ($urandom_range(9) == 0) begin
          poll_ms = $urandom();
        end else begin
          poll_ms = gen_t_us / 1000 + $urandom_range(0, 6000);
        end
        it = mk_poll(poll_ms, 1'($urandom_range(1)));
        done_cnt++;
      end else begin
        it.cmd          = 1'($urandom_range(1));
        it.edge_time_us = $urandom();
        it.pin_level    = 1'($urandom_range(1));
        it.poll_time_ms = $urandom();
        done_cnt++;
      end
      send_item(it);
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    lbpc_cfg_t windows;
    rst_n         <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    stall_req     <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    load_windows(CFG_RESET);

    // directed: level starts high, level start 0
    send_item(mk_poll(32'd0, 1'b1));          // fresh poll, not quiet
    send_item(mk_edge(32'd0, 1'b1));          // no level change
    send_item(mk_edge(32'd2000, 1'b0));       // 2 ms glitch
    send_item(mk_edge(32'd102000, 1'b1));     // on time only, no period yet
    send_item(mk_edge(32'd202000, 1'b0));     // 100/100 -> fast
    send_item(mk_edge(32'd802000, 1'b1));     // no window, pattern held
    send_item(mk_edge(32'd1402000, 1'b0));    // 600/600 -> slow
    send_item(mk_poll(32'd4401, 1'b0));       // one ms short of quiet
    send_item(mk_poll(32'd4402, 1'b0));       // quiet, LED on -> solid
    send_item(mk_poll(32'd4402, 1'b1));       // quiet, LED off -> off
    send_item(mk_edge(32'd71402000, 1'b1));   // duration saturates
    send_item(mk_edge(32'hFFFF_FFFF, 1'b0));  // top timestamp, period saturates
    send_item(mk_edge(32'd65536, 1'b1));      // timestamp wraps
    send_item(mk_poll(32'hFFFF_FFFF, 1'b1));
    send_item(mk_poll(32'd64, 1'b0));         // poll time behind last edge wraps
    send_item(mk_poll(32'd3064, 1'b0));       // 2999 ms idle, not yet quiet
    send_item(mk_edge(32'd80000, 1'b1));      // no level change
    send_item(mk_edge(32'd70535, 1'b0));      // 4.999 ms glitch
    send_item(mk_edge(32'd75535, 1'b1));      // exactly 5 ms accepted
    in_ch.valid <= 1'b0;
    wait_drained();
    gen_t_us = 32'd75535;
    gen_lvl  = 1'b1;

    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0, 5: windows = CFG_RESET;
        1: windows = rand_windows(1'b0);
        2: windows = '{fast: '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF},
                       slow: '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}};
        3: windows = '{fast: '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000},
                       slow: '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}};
        default: windows = rand_windows(1'b1);
      endcase
      if (seg < 2) begin
        src_idle_pct = 34;
        snk_idle_pct = 66;
      end else if (seg < 4) begin
        src_idle_pct = 66;
        snk_idle_pct = 34;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      load_windows(windows);
      if (seg == 4) begin
        stall_req <= 1'b1;
      end
      run_random(SEGMENT_ITEMS);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lbpc_pkg.sv
rtl/lbpc_stream_if.sv
rtl/lbpc_cfg.sv
rtl/lbpc_front.sv
rtl/lbpc_classify.sv
rtl/led_blink_pattern_classifier_top.sv
dv/lbpc_tb_pkg.sv
dv/lbpc_pattern_checker.sv
dv/tb_led_blink_pattern_classifier_top.sv
